### design/hbrpd_pkg.sv
// ----------------------------------------------------------------------------
// hbrpd_pkg: shared types and constants of the H-bridge ramp PWM driver
// Holds the channel payloads, operation and register codes, the per-side
// motion state and the fixed-point constants of the trim divider.
// ----------------------------------------------------------------------------
package hbrpd_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_SET_TARGETS = 2'd0;
  localparam logic [1:0] OP_TICK        = 2'd1;
  localparam logic [1:0] OP_STOP        = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEFT_TRIM  = 3'd0;
  localparam logic [2:0] REG_RIGHT_TRIM = 3'd1;
  localparam logic [2:0] REG_MAX_PWM    = 3'd2;
  localparam logic [2:0] REG_RAMP_STEP  = 3'd3;
  localparam logic [2:0] REG_MIN_PWM    = 3'd4;
  localparam logic [2:0] REG_BLANK      = 3'd5;
  localparam logic [2:0] REG_DRIVE_MODE = 3'd6;
  localparam logic [2:0] REG_POLARITY   = 3'd7;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Direction codes, two-bit two's complement: -1, 0, +1.
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  // Drive mode: coast puts PWM on the direction input, brake holds it high.
  localparam logic MODE_BRAKE = 1'b1;

  // Full-scale duty of a bridge input.
  localparam logic [7:0] PWM_FULL_SCALE = 8'd255;

  // Trim scale base and the rounding offset for the divide by 1000.
  localparam logic [10:0] TRIM_BASE   = 11'd1000;
  localparam logic [25:0] ROUND_HALF  = 26'd500;
  // Rounded products at or above this value always clamp (quotient >= 256).
  localparam logic [25:0] QUOT_LIMIT  = 26'd256000;
  // Reciprocal of 1000 scaled by 2^28, rounded up; exact below QUOT_LIMIT.
  localparam logic [18:0] RECIP_1000  = 19'd268436;
  localparam int unsigned DIV_SHIFT   = 28;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] left_target;
    logic signed [15:0] right_target;
  } hbrpd_in_t;

  typedef struct packed {
    logic [7:0] left_ia_duty;
    logic [7:0] left_ib_duty;
    logic [7:0] right_ia_duty;
    logic [7:0] right_ib_duty;
    logic       emergency_stop;
  } hbrpd_out_t;

  // Motion state of one motor side.
  typedef struct packed {
    logic signed [8:0] cur;
    logic [7:0]        blank;
    logic [1:0]        last;
  } side_t;

endpackage

### design/hbrpd_if.sv
// ----------------------------------------------------------------------------
// hbrpd_if: valid/ready channels of the H-bridge ramp PWM driver
// One interface for input items and one for result items; a transfer takes
// place at a rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface hbrpd_in_if
  import hbrpd_pkg::*;
  ;
  logic      valid;
  logic      ready;
  hbrpd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hbrpd_out_if
  import hbrpd_pkg::*;
  ;
  logic       valid;
  logic       ready;
  hbrpd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/hbridge_ramp_pwm_driver.sv
// ----------------------------------------------------------------------------
// hbridge_ramp_pwm_driver: two-motor H-bridge drive with trim and ramping
// Set-targets, tick and stop items pass a four-stage pipeline; the last
// stage updates the motion state and fills the result register.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the pipeline does not
// stall. An item passes an input register, a stage that scales each requested
// speed by the trim factor, a stage that divides by 1000 with a reciprocal
// multiply and clamps to max_pwm, and finally the execute stage, which
// updates the per-side ramp state and loads the result register. A tick or
// stop result is loaded there as its item leaves the execute stage; a
// set-targets item takes effect there and leaves no result. The pipeline stalls
// only when a tick or stop reaches the execute stage while the result register
// still holds an untaken result. There is no clearing pass after reset.
module hbridge_ramp_pwm_driver
  import hbrpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hbrpd_in_if.sink              in_ch,
  hbrpd_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic signed [9:0] left_trim_r;
  logic signed [9:0] right_trim_r;
  logic [7:0]        max_pwm_r;
  logic [7:0]        ramp_step_r;
  logic [7:0]        min_pwm_r;
  logic [7:0]        blank_ticks_r;
  logic              drive_mode_r;
  logic [3:0]        polarity_r;

  // Pipeline registers.
  logic              v1_r, v2_r, v3_r;
  hbrpd_in_t         in_r;
  logic [1:0]        op2_r, op3_r;
  logic [25:0]       prod2_r [2];
  logic              neg2_r  [2];
  logic [25:0]       prod_nxt [2];
  logic signed [8:0] tgt3_r   [2];
  logic signed [8:0] tgt3_nxt [2];

  // Motion state.
  logic signed [8:0] target_r [2];
  side_t             side_r   [2];
  side_t             side_nxt [2];

  // Result register.
  logic              out_valid_r;
  hbrpd_out_t        out_r;
  hbrpd_out_t        out_nxt;

  logic              exec_has_out;
  logic              adv3, rdy3, rdy2, rdy1;
  logic              in_xfer;

  // --------------------------------------------------------------------------
  // Helper functions of the execute stage
  // --------------------------------------------------------------------------

  function automatic logic [1:0] sign_of(input logic signed [8:0] v);
    logic [1:0] d;
    if (v > 9'sd0) begin
      d = DIR_FWD;
    end else if (v < 9'sd0) begin
      d = DIR_REV;
    end else begin
      d = DIR_NONE;
    end
    return d;
  endfunction

  // One ramp step of cur toward tgt, with the kick when leaving zero.
  function automatic logic signed [8:0] ramp(input logic signed [8:0] cur,
                                              input logic signed [8:0] tgt);
    logic signed [10:0] c, t, m, st, nx, r;
    c  = $signed({{2{cur[8]}}, cur});
    t  = $signed({{2{tgt[8]}}, tgt});
    m  = $signed({3'b000, min_pwm_r});
    st = $signed({3'b000, ramp_step_r});
    if (c == t) begin
      r = c;
    end else if (c < t) begin
      nx = c + st;
      r  = (nx > t) ? t : nx;
      if (c <= 11'sd0 && t > 11'sd0 && min_pwm_r != 8'd0) begin
        r = (t < m) ? t : m;
      end
    end else begin
      nx = c - st;
      r  = (nx < t) ? t : nx;
      if (c >= 11'sd0 && t < 11'sd0 && min_pwm_r != 8'd0) begin
        r = (t > -m) ? t : -m;
      end
    end
    return r[8:0];
  endfunction

  // Blanking, reversal and ramping for one side on a tick.
  function automatic side_t step_side(input side_t st, input logic signed [8:0] tgt);
    side_t      res;
    logic [1:0] ts, cs;
    res = st;
    ts  = sign_of(tgt);
    cs  = sign_of(st.cur);
    if (st.blank != 8'd0) begin
      res.cur   = '0;
      res.blank = st.blank - 8'd1;
    end else if (st.cur != 9'sd0 && ts != DIR_NONE && cs != ts) begin
      res.cur = ramp(st.cur, 9'sd0);
      if (res.cur == 9'sd0) begin
        res.last  = ts;
        res.blank = blank_ticks_r;
      end
    end else if (st.cur == 9'sd0 && ts != DIR_NONE && st.last != DIR_NONE &&
                 ts != st.last) begin
      res.last  = ts;
      res.blank = blank_ticks_r;
    end else begin
      res.cur = ramp(st.cur, tgt);
      if (res.cur != 9'sd0) begin
        res.last = sign_of(res.cur);
      end
    end
    return res;
  endfunction

  // Bridge input duties {ia, ib} of one side.
  function automatic logic [15:0] map_side(input logic signed [8:0] spd,
                                           input logic invert, input logic fwd_ib);
    logic signed [9:0] cmd;
    logic [9:0]        mag;
    logic [7:0]        duty, inv, ia, ib;
    logic              dir_ib;
    cmd    = invert ? -$signed({spd[8], spd}) : $signed({spd[8], spd});
    mag    = cmd[9] ? 10'(-cmd) : 10'(cmd);
    duty   = mag[7:0];
    dir_ib = ((cmd > 10'sd0) == fwd_ib);
    inv    = (duty > PWM_FULL_SCALE) ? 8'd0 : PWM_FULL_SCALE - duty;
    ia     = 8'd0;
    ib     = 8'd0;
    if (cmd != 10'sd0) begin
      if (drive_mode_r == MODE_BRAKE) begin
        if (dir_ib) begin
          ib = PWM_FULL_SCALE;
          ia = inv;
        end else begin
          ia = PWM_FULL_SCALE;
          ib = inv;
        end
      end else if (dir_ib) begin
        ib = duty;
      end else begin
        ia = duty;
      end
    end
    return {ia, ib};
  endfunction

  // --------------------------------------------------------------------------
  // Handshake and stage advance
  // --------------------------------------------------------------------------

  // Only ticks and stops need the result register.
  assign exec_has_out = (op3_r == OP_TICK) || (op3_r == OP_STOP);
  assign adv3    = v3_r && (!exec_has_out || !out_valid_r || out_ch.ready);
  assign rdy3    = !v3_r || adv3;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign in_xfer = in_ch.valid && rdy1;

  assign in_ch.ready  = rdy1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // --------------------------------------------------------------------------
  // Trim multiply: |target| * (1000 + trim) + 500
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [15:0] req  [2];
    logic signed [9:0]  trim [2];
    logic [15:0]        mag;
    logic [10:0]        fac;
    req[0]  = in_r.left_target;
    req[1]  = in_r.right_target;
    trim[0] = left_trim_r;
    trim[1] = right_trim_r;
    for (int s = 0; s < 2; s++) begin
      mag = req[s][15] ? 16'(-req[s]) : 16'(req[s]);
      fac = TRIM_BASE + {trim[s][9], trim[s]};
      prod_nxt[s] = ({10'd0, mag} * {15'd0, fac}) + ROUND_HALF;
    end
  end

  // --------------------------------------------------------------------------
  // Divide by 1000 through the reciprocal, clamp, and restore the sign
  // --------------------------------------------------------------------------
  always_comb begin
    logic [36:0] qp;
    logic [7:0]  q8;
    logic [7:0]  qmag;
    for (int s = 0; s < 2; s++) begin
      qp   = {19'd0, prod2_r[s][17:0]} * {18'd0, RECIP_1000};
      q8   = qp[DIV_SHIFT +: 8];
      qmag = (prod2_r[s] >= QUOT_LIMIT || q8 > max_pwm_r) ? max_pwm_r : q8;
      tgt3_nxt[s] = neg2_r[s] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
  end

  // --------------------------------------------------------------------------
  // Execute stage: next motion state and result
  // --------------------------------------------------------------------------
  always_comb begin
    logic [15:0] lmap, rmap;
    for (int s = 0; s < 2; s++) begin
      side_nxt[s] = step_side(side_r[s], target_r[s]);
    end
    lmap = map_side(side_nxt[0].cur, polarity_r[0], polarity_r[2]);
    rmap = map_side(side_nxt[1].cur, polarity_r[1], polarity_r[3]);
    out_nxt = '0;
    if (op3_r == OP_TICK) begin
      out_nxt.left_ia_duty  = lmap[15:8];
      out_nxt.left_ib_duty  = lmap[7:0];
      out_nxt.right_ia_duty = rmap[15:8];
      out_nxt.right_ib_duty = rmap[7:0];
    end else begin
      out_nxt.emergency_stop = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers: configuration, stage valids, state, result valid
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_trim_r   <= '0;
      right_trim_r  <= '0;
      max_pwm_r     <= 8'd255;
      ramp_step_r   <= 8'd8;
      min_pwm_r     <= 8'd0;
      blank_ticks_r <= 8'd2;
      drive_mode_r  <= 1'b0;
      polarity_r    <= 4'd0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        target_r[s] <= '0;
        side_r[s]   <= '0;
      end
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        case (cfg_addr)
          REG_LEFT_TRIM:  left_trim_r   <= $signed(cfg_wdata[9:0]);
          REG_RIGHT_TRIM: right_trim_r  <= $signed(cfg_wdata[9:0]);
          REG_MAX_PWM:    max_pwm_r     <= cfg_wdata[7:0];
          REG_RAMP_STEP:  ramp_step_r   <= cfg_wdata[7:0];
          REG_MIN_PWM:    min_pwm_r     <= cfg_wdata[7:0];
          REG_BLANK:      blank_ticks_r <= cfg_wdata[7:0];
          REG_DRIVE_MODE: drive_mode_r  <= cfg_wdata[0];
          REG_POLARITY:   polarity_r    <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      // Stage valids move forward wherever the next stage has room.
      if (rdy1) begin
        v1_r <= in_ch.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end

      // Motion state changes only when an item leaves the execute stage.
      if (adv3) begin
        case (op3_r)
          OP_SET_TARGETS: begin
            target_r[0] <= tgt3_r[0];
            target_r[1] <= tgt3_r[1];
          end
          OP_TICK: begin
            side_r[0] <= side_nxt[0];
            side_r[1] <= side_nxt[1];
          end
          OP_STOP: begin
            for (int s = 0; s < 2; s++) begin
              target_r[s] <= '0;
              side_r[s]   <= '0;
            end
          end
          default: ;
        endcase
      end

      // Result register valid.
      if (adv3 && exec_has_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_ch.data;
    end
    if (rdy2) begin
      op2_r      <= in_r.opcode;
      prod2_r[0] <= prod_nxt[0];
      prod2_r[1] <= prod_nxt[1];
      neg2_r[0]  <= in_r.left_target[15];
      neg2_r[1]  <= in_r.right_target[15];
    end
    if (rdy3) begin
      op3_r     <= op2_r;
      tgt3_r[0] <= tgt3_nxt[0];
      tgt3_r[1] <= tgt3_nxt[1];
    end
    if (adv3 && exec_has_out) begin
      out_r <= out_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A running dead-time blank always holds its side at zero speed.
  a_blank_holds_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (side_r[0].blank == 8'd0 || side_r[0].cur == 9'sd0) &&
    (side_r[1].blank == 8'd0 || side_r[1].cur == 9'sd0))
    else $error("blank counter running with nonzero speed");

  // A stop leaving the execute stage clears the whole motion state.
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv3 && op3_r == OP_STOP) |=>
      (side_r[0] == '0 && side_r[1] == '0 &&
       target_r[0] == 9'sd0 && target_r[1] == 9'sd0))
    else $error("emergency stop left motion state behind");

  // An emergency-stop result carries all duties at zero.
  a_stop_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.emergency_stop) |->
      (out_r.left_ia_duty == 8'd0 && out_r.left_ib_duty == 8'd0 &&
       out_r.right_ia_duty == 8'd0 && out_r.right_ib_duty == 8'd0))
    else $error("emergency-stop result with nonzero duty");

  // A pending result is never overwritten before its transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(adv3 && exec_has_out))
    else $error("result register overwritten while stalled");

endmodule

### tb/tb_hbridge_ramp_pwm_driver.sv
// ----------------------------------------------------------------------------
// tb_hbridge_ramp_pwm_driver: self-checking bench for the H-bridge driver
// Walks a short table of directed items and then runs eight random phases,
// each with its own register setting and one of four idle/stall patterns. A
// behavioral motion model predicts every tick and stop result; a scoreboard
// compares each result transfer, field by field, against it or a table value.
// ----------------------------------------------------------------------------
module tb_hbridge_ramp_pwm_driver;
  import hbrpd_pkg::*;

  // Opcode that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 86;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 8;
  localparam int QUIET_LIMIT = 3000;
  localparam int NPLAN       = 31;

  localparam hbrpd_out_t IDLE_DUTY  = '0;
  localparam hbrpd_out_t ESTOP_DUTY = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
  localparam hbrpd_out_t FIRST_STEP = '{8'd8, 8'd0, 8'd0, 8'd8, 1'b0};

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an item, or a register write.
  typedef struct {
    row_kind_t          kind;
    logic [1:0]         op;
    logic signed [15:0] lt;
    logic signed [15:0] rt;
    bit                 typed;
    hbrpd_out_t         want;
    logic [2:0]         reg_idx;
    logic [9:0]         reg_val;
  } plan_row_t;

  // Hand-written expectation that travels with an item.
  typedef struct {
    bit         typed;
    hbrpd_out_t want;
  } note_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hbrpd_in_if  in_ch();
  hbrpd_out_if out_ch();

  hbridge_ramp_pwm_driver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Register mirror, at reset values.
  int         trim_l     = 0;
  int         trim_r     = 0;
  int         lim_pwm    = 255;
  int         ramp_inc   = 8;
  int         kick_pwm   = 0;
  int         dead_ticks = 2;
  logic       brake_on   = 1'b0;
  logic [3:0] pol_sel    = 4'd0;

  // Motion state of both sides.
  int side_tgt[2]   = '{0, 0};
  int side_cur[2]   = '{0, 0};
  int side_blank[2] = '{0, 0};
  int side_dir[2]   = '{0, 0};

  hbrpd_out_t duty_q[$];
  note_t      note_q[$];

  int fails;
  int quiet;
  int n_set, n_tick, n_stop, n_ignored, n_checked, n_settings;
  int send_pct;
  int stall_pct;
  bit hold_req;

  plan_row_t  dir_plan[NPLAN];
  hbrpd_out_t got_r;
  hbrpd_out_t exp_r;
  hbrpd_out_t pred_r;
  bit         pred_has;
  note_t      cur_note;

  function automatic int sgn(int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Trim scaling: multiply, round half away from zero, clamp to +/- max PWM.
  function automatic int scale_target(logic signed [15:0] v, int trim);
    longint prod;
    longint rnd;
    longint quo;
    prod = longint'(v) * longint'(1000 + trim);
    rnd  = (prod >= 0) ? prod + 500 : prod - 500;
    quo  = rnd / 1000;
    if (quo > lim_pwm) quo = lim_pwm;
    if (quo < -lim_pwm) quo = -lim_pwm;
    return int'(quo);
  endfunction

  // One ramp step toward t, with the kick when leaving zero.
  function automatic int ramp_to(int c, int t);
    int k;
    int nx;
    if (c == t) return c;
    if (c < t) begin
      if (c <= 0 && t > 0 && kick_pwm > 0) begin
        k = (t < kick_pwm) ? t : kick_pwm;
        if (k > c) return k;
      end
      nx = c + ramp_inc;
      return (nx > t) ? t : nx;
    end
    if (c >= 0 && t < 0 && kick_pwm > 0) begin
      k = (t > -kick_pwm) ? t : -kick_pwm;
      if (k < c) return k;
    end
    nx = c - ramp_inc;
    return (nx < t) ? t : nx;
  endfunction

  // Tick update of one side: blanking, reversal, or plain ramping.
  function automatic void advance_side(int s);
    int ts;
    int cs;
    ts = sgn(side_tgt[s]);
    cs = sgn(side_cur[s]);
    if (side_blank[s] > 0) begin
      side_cur[s] = 0;
      side_blank[s]--;
      return;
    end
    if (side_cur[s] != 0 && ts != 0 && cs != ts) begin
      side_cur[s] = ramp_to(side_cur[s], 0);
      if (side_cur[s] == 0) begin
        side_dir[s]   = ts;
        side_blank[s] = dead_ticks;
      end
      return;
    end
    if (side_cur[s] == 0 && ts != 0 && side_dir[s] != 0 && ts != side_dir[s]) begin
      side_dir[s]   = ts;
      side_blank[s] = dead_ticks;
      return;
    end
    side_cur[s] = ramp_to(side_cur[s], side_tgt[s]);
    if (side_cur[s] != 0) side_dir[s] = sgn(side_cur[s]);
  endfunction

  // Map a signed speed onto the two bridge inputs of one side.
  function automatic void bridge_duty(int speed, bit inv, bit fwd_ib,
                                      output logic [7:0] ia, output logic [7:0] ib);
    int cmd;
    int mag;
    int rest;
    bit dir_ib;
    ia = '0;
    ib = '0;
    cmd = inv ? -speed : speed;
    if (cmd == 0) return;
    mag    = ((cmd < 0) ? -cmd : cmd) & 255;
    dir_ib = ((cmd > 0) == fwd_ib);
    if (brake_on == MODE_BRAKE) begin
      rest = (mag > int'(PWM_FULL_SCALE)) ? 0 : int'(PWM_FULL_SCALE) - mag;
      if (dir_ib) begin
        ib = PWM_FULL_SCALE;
        ia = 8'(rest);
      end else begin
        ia = PWM_FULL_SCALE;
        ib = 8'(rest);
      end
    end else if (dir_ib) begin
      ib = 8'(mag);
    end else begin
      ia = 8'(mag);
    end
  endfunction

  // Motion model: applies one item and gives the result it causes, if any.
  function automatic void drive_step(input hbrpd_in_t it, output bit has,
                                     output hbrpd_out_t r);
    logic [7:0] a;
    logic [7:0] b;
    r   = '0;
    has = 1'b0;
    case (it.opcode)
      OP_SET_TARGETS: begin
        side_tgt[0] = scale_target(it.left_target, trim_l);
        side_tgt[1] = scale_target(it.right_target, trim_r);
      end
      OP_TICK: begin
        advance_side(0);
        advance_side(1);
        bridge_duty(side_cur[0], pol_sel[0], pol_sel[2], a, b);
        r.left_ia_duty = a;
        r.left_ib_duty = b;
        bridge_duty(side_cur[1], pol_sel[1], pol_sel[3], a, b);
        r.right_ia_duty = a;
        r.right_ib_duty = b;
        has = 1'b1;
      end
      OP_STOP: begin
        for (int s = 0; s < 2; s++) begin
          side_tgt[s]   = 0;
          side_cur[s]   = 0;
          side_blank[s] = 0;
          side_dir[s]   = 0;
        end
        r.emergency_stop = 1'b1;
        has = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fails++;
    end
  endfunction

  // Scoreboard and watchdog: both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_r = out_ch.data;
        if (duty_q.size() == 0) begin
          $error("result transfer with no result pending");
          fails++;
        end else begin
          exp_r = duty_q.pop_front();
          check_field("left_ia_duty", exp_r.left_ia_duty, got_r.left_ia_duty);
          check_field("left_ib_duty", exp_r.left_ib_duty, got_r.left_ib_duty);
          check_field("right_ia_duty", exp_r.right_ia_duty, got_r.right_ia_duty);
          check_field("right_ib_duty", exp_r.right_ib_duty, got_r.right_ib_duty);
          check_field("emergency_stop", exp_r.emergency_stop, got_r.emergency_stop);
          n_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (note_q.size() != 0) begin
          cur_note = note_q.pop_front();
        end else begin
          cur_note.typed = 1'b0;
          cur_note.want  = IDLE_DUTY;
        end
        drive_step(in_ch.data, pred_has, pred_r);
        if (pred_has) duty_q.push_back(cur_note.typed ? cur_note.want : pred_r);
        case (in_ch.data.opcode)
          OP_SET_TARGETS: n_set++;
          OP_TICK:        n_tick++;
          OP_STOP:        n_stop++;
          default:        n_ignored++;
        endcase
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_ch.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 1'b0;
    end
    out_ch.ready <= !($urandom_range(0, 99) < stall_pct);
  end

  // Offer one item, with random idle cycles first; returns at its transfer.
  task automatic send_item(input hbrpd_in_t it, input bit typed, input hbrpd_out_t want);
    while ($urandom_range(0, 99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    note_q.push_back('{typed, want});
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every result is in and the pipe is empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (duty_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LEFT_TRIM:  trim_l     = int'($signed(val));
      REG_RIGHT_TRIM: trim_r     = int'($signed(val));
      REG_MAX_PWM:    lim_pwm    = int'(val[7:0]);
      REG_RAMP_STEP:  ramp_inc   = int'(val[7:0]);
      REG_MIN_PWM:    kick_pwm   = int'(val[7:0]);
      REG_BLANK:      dead_ticks = int'(val[7:0]);
      REG_DRIVE_MODE: brake_on   = val[0];
      default:        pol_sel    = val[3:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_target();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'(int'($urandom_range(0, 600)) - 300);
      6, 7:             return 16'($urandom_range(0, 65535));
      8: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      default:          return 16'sd0;
    endcase
  endfunction

  // Mostly ticks and target updates, so that ramps and reversals play out.
  function automatic hbrpd_in_t rand_item();
    hbrpd_in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.opcode       = (pick < 60) ? OP_TICK : (pick < 90) ? OP_SET_TARGETS :
                      (pick < 95) ? OP_STOP : OP_UNUSED;
    it.left_target  = rand_target();
    it.right_target = rand_target();
    return it;
  endfunction

  // Register values of one random phase; the first two are the extremes.
  task automatic apply_setting(input int ph);
    logic [9:0] val[8];
    int t;
    if (ph == 0) begin
      val = '{10'h200, 10'h1FF, 10'd255, 10'd255, 10'd255, 10'd0, 10'd1, 10'd15};
    end else if (ph == 1) begin
      val = '{10'h1FF, 10'h200, 10'd1, 10'd1, 10'd0, 10'd255, 10'd0, 10'd0};
    end else begin
      for (int s = 0; s < 2; s++) begin
        t = int'($urandom_range(0, 1000)) - 500;
        val[s] = $urandom_range(0, 1) ? t[9:0] : 10'($urandom_range(0, 1023));
      end
      case ($urandom_range(0, 4))
        0:       val[REG_MAX_PWM] = 10'd0;
        1:       val[REG_MAX_PWM] = 10'd1;
        2:       val[REG_MAX_PWM] = 10'd255;
        default: val[REG_MAX_PWM] = 10'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       val[REG_RAMP_STEP] = 10'd0;
        1:       val[REG_RAMP_STEP] = 10'd255;
        default: val[REG_RAMP_STEP] = 10'($urandom_range(1, 24));
      endcase
      val[REG_MIN_PWM]    = $urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(1, 255));
      val[REG_BLANK]      = ($urandom_range(0, 5) != 0) ? 10'($urandom_range(0, 4))
                                                         : 10'($urandom_range(5, 40));
      val[REG_DRIVE_MODE] = 10'($urandom_range(0, 1));
      val[REG_POLARITY]   = 10'($urandom_range(0, 15));
    end
    for (int r = 0; r < 8; r++) cfg_write(3'(r), val[r]);
    n_settings++;
  endtask

  initial begin
    hbrpd_in_t it;
    int n;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    hold_req      = 1'b0;
    send_pct      = 0;
    stall_pct     = 0;
    fails         = 0;
    quiet         = 0;
    n_set         = 0;
    n_tick        = 0;
    n_stop        = 0;
    n_ignored     = 0;
    n_checked     = 0;
    n_settings    = 0;

    // Directed table: reset behavior, extremes, reversal with dead time,
    // kick, brake mode with full polarity swap, zero step and zero clamp.
    dir_plan = '{
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b1, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_STOP,        16'sd0,    16'sd0,    1'b1, ESTOP_DUTY, REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_UNUSED,      16'sh1234, 16'sh5678, 1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_SET_TARGETS, 16'sh7FFF, 16'sh8000, 1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b1, FIRST_STEP, REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_SET_TARGETS, -16'sd100, 16'sd100,  1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_CFG,  OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MIN_PWM, 10'd40},
      '{ROW_CFG,  OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_DRIVE_MODE,
        {9'd0, MODE_BRAKE}},
      '{ROW_CFG,  OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_POLARITY, 10'd15},
      '{ROW_ITEM, OP_SET_TARGETS, 16'sd30,   -16'sd300, 1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_CFG,  OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_RAMP_STEP, 10'd0},
      '{ROW_CFG,  OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_BLANK, 10'd0},
      '{ROW_ITEM, OP_SET_TARGETS, -16'sd30,  16'sd300,  1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_CFG,  OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_LEFT_TRIM, 10'h200},
      '{ROW_CFG,  OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_RIGHT_TRIM,
        10'h1FF},
      '{ROW_ITEM, OP_STOP,        16'sd0,    16'sd0,    1'b1, ESTOP_DUTY, REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_SET_TARGETS, 16'sh8000, 16'sh7FFF, 1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_CFG,  OP_SET_TARGETS, 16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0},
      '{ROW_ITEM, OP_TICK,        16'sd0,    16'sd0,    1'b0, IDLE_DUTY,  REG_MAX_PWM, 10'd0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk; register rows wait for the block to go idle.
    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_plan[i].reg_idx, dir_plan[i].reg_val);
      end else begin
        it.opcode       = dir_plan[i].op;
        it.left_target  = dir_plan[i].lt;
        it.right_target = dir_plan[i].rt;
        send_item(it, dir_plan[i].typed, dir_plan[i].want);
      end
    end

    // Random phases, cycling through the four idle/stall patterns.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      apply_setting(ph);
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 49; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 49; end
        default: begin send_pct = 23; stall_pct = 23; end
      endcase
      // One phase starts with a long result hold-off so the pipe backs up.
      if (ph == 4) hold_req = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        it = rand_item();
        send_item(it, 1'b0, IDLE_DUTY);
        if (it.opcode != OP_UNUSED) n++;
      end
    end

    settle();
    $display("Covered %0d set-targets, %0d ticks, %0d stops and %0d ignored items",
             n_set, n_tick, n_stop, n_ignored);
    $display("under %0d register settings; %0d results checked", n_settings, n_checked);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
